// ===== hw/rtl/bdq_pkg.sv =====
package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

// ===== hw/rtl/bounded_deque_with_remove_by_value.sv =====
// Bounded deque of up to DEPTH signed entries held in a ring buffer in one
// single-port-read RAM. Every command returns exactly one result: a status
// and the entry count after the command. Pushes, pops and unknown commands
// finish in the cycle they are accepted, so one such command can be taken
// every cycle while the output is not stalled; the result is then registered
// into the output register. A remove-by-value walks the store from the
// front, a RAM read and then a compare per entry examined, then closes the
// gap behind the first match by a read and then a write back per entry moved;
// the RAM read is registered. While a walk is in progress, or while a
// finished result cannot enter an output register that is still held by a
// stalled transaction, req_stall stays high.
module bounded_deque_with_remove_by_value
    import bdq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic signed [VALUE_W-1:0] value,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  count
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_HOLD = 3'd5;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(DEPTH))
        begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ADDR_W-1:0]     off_reg, off_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [STATUS_W-1:0]   pend_reg, pend_next;

    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

    logic                  req_accept;
    logic                  rsp_free;
    logic                  fin;
    logic [STATUS_W-1:0]   fin_status;
    logic [CNT_W:0]        off_inc1, off_inc2;

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign off_inc1   = (CNT_W + 1)'(off_reg) + (CNT_W + 1)'(1);
    assign off_inc2   = (CNT_W + 1)'(off_reg) + (CNT_W + 1)'(2);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        cnt_next       = cnt_reg;
        off_next       = off_reg;
        val_next       = val_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = ring_add(front_reg, CNT_W'(off_reg));
        mem_raddr      = ring_add(front_reg, CNT_W'(off_reg));
        mem_wdata      = mem_rdata;
        fin            = 1'b0;
        fin_status     = ST_DONE;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    val_next = DATA_WIDTH'(value);
                    fin      = 1'b1;
                    unique case (cmd)
                        CMD_PUSH_FRONT:
                        begin
                            if (cnt_reg >= CNT_FULL)
                            begin
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = ring_add(front_reg, CNT_W'(DEPTH - 1));
                                mem_wdata  = DATA_WIDTH'(value);
                                front_next = ring_add(front_reg, CNT_W'(DEPTH - 1));
                                cnt_next   = cnt_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (cnt_reg >= CNT_FULL)
                            begin
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ring_add(front_reg, cnt_reg);
                                mem_wdata = DATA_WIDTH'(value);
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = ring_add(front_reg, CNT_W'(1));
                                cnt_next   = cnt_reg - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                fin        = 1'b0;
                                off_next   = '0;
                                state_next = S_SRD;
                            end
                        end
                        default:
                        begin
                            fin_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_SRD:
            begin
                mem_re     = 1'b1;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (mem_rdata == val_reg)
                begin
                    if (off_inc1 < (CNT_W + 1)'(cnt_reg))
                    begin
                        state_next = S_MRD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                        fin      = 1'b1;
                    end
                end
                else if (off_inc1 == (CNT_W + 1)'(cnt_reg))
                begin
                    fin        = 1'b1;
                    fin_status = ST_NOMATCH;
                end
                else
                begin
                    off_next   = off_inc1[ADDR_W-1:0];
                    state_next = S_SRD;
                end
            end
            S_MRD:
            begin
                // fetch the entry behind the hole
                mem_re     = 1'b1;
                mem_raddr  = ring_add(front_reg, off_inc1[CNT_W-1:0]);
                state_next = S_MWR;
            end
            S_MWR:
            begin
                mem_we   = 1'b1;
                off_next = off_inc1[ADDR_W-1:0];
                if (off_inc2 < (CNT_W + 1)'(cnt_reg))
                begin
                    state_next = S_MRD;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    fin      = 1'b1;
                end
            end
            S_HOLD:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = pend_reg;
                    count_next     = cnt_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (rsp_free)
            begin
                rsp_valid_next = 1'b1;
                status_next    = fin_status;
                count_next     = cnt_next;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_next  = fin_status;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            cnt_reg       <= '0;
            off_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            cnt_reg       <= cnt_next;
            off_reg       <= off_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        status_reg <= status_next;
        count_reg  <= count_next;
        pend_reg   <= pend_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign count     = COUNT_W'(count_reg);

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("entry count above depth");

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("RAM read and write in the same cycle");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)
        && cnt_reg < CNT_FULL |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("push did not grow the count");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK)
        && cnt_reg == '0 && rsp_free |=> rsp_valid_reg && status_reg == ST_EMPTY)
        else $error("pop on empty store not flagged");
`endif

endmodule

// ===== hw/rtl/bdq_ram.sv =====
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
